// ===== sv/cfc_pkg.sv =====
// Shared types, constants and helper functions for the circular FIFO with statistics.
package cfc_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 5;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 64;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cfc_cmd_t;

  typedef enum logic [1:0] {
    FILL_EMPTY   = 2'd0,
    FILL_PARTIAL = 2'd1,
    FILL_FULL    = 2'd2
  } cfc_fill_t;

  typedef struct packed {
    cfc_cmd_t          command;
    logic [63:0]       item_data;
  } cfc_in_t;

  typedef struct packed {
    logic              status;
    logic [63:0]       read_data;
    logic [OCC_W-1:0]  occupancy;
    cfc_fill_t         fill_state;
    logic [STAT_W-1:0] enqueued_total;
    logic [STAT_W-1:0] dequeued_total;
    logic [STAT_W-1:0] overflow_total;
  } cfc_out_t;

  // Per-transfer events toward the statistics counters
  typedef struct packed {
    logic enq_ok;
    logic deq_ok;
    logic ovf;
  } cfc_evt_t;

  // Response state from the controller, valid in the cycle after acceptance
  typedef struct packed {
    logic             done;
    logic             status;
    logic             rd_ok;
    logic [CNT_W-1:0] fill;
    cfc_fill_t        fstate;
  } cfc_resp_t;

  // Clamp the programmed capacity into 1..DEPTH
  function automatic logic [CNT_W-1:0] cap_eff(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (cap == '0) begin
      res = CNT_W'(1);
    end else if (32'(cap) > DEPTH) begin
      res = CNT_W'(DEPTH);
    end else begin
      res = CNT_W'(cap);
    end
    return res;
  endfunction

  // Step a pointer, wrapping at the capacity in use
  function automatic logic [AW-1:0] ptr_adv(input logic [AW-1:0] ptr,
                                            input logic [CNT_W-1:0] cap);
    logic [AW:0] n;
    n = {1'b0, ptr} + (AW+1)'(1);
    return (n >= (AW+1)'(cap)) ? '0 : n[AW-1:0];
  endfunction

endpackage

// ===== sv/circular_fifo_with_stats.sv =====
// Top level of the circular FIFO with enqueue, dequeue and overflow statistics.
//
// Usage:
//   Command channel: present cmd with start high; it transfers at a rising
//   edge where start is high and busy is low. busy stays low, so a command
//   may be issued every cycle.
//   Result channel: done is high in the cycle after each command transfer,
//   with result valid in that cycle. The receiver cannot
//   stall; it must take the result in that cycle.
//   Throughput is one command per cycle: the entry store is a RAM with a
//   registered read, issued at the transfer edge, and its output feeds
//   read_data directly in the result cycle.
//   Configuration: cfg_valid/cfg_ready write capacity_in_use (cfg_ready is
//   always high). Write it only while no result is pending.
//   Reset (rst, synchronous): empties the FIFO, zeroes the three counters
//   and sets the capacity in use to 16. The entry store is not cleared;
//   entries are only read after being written.
module circular_fifo_with_stats (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  cfc_pkg::cfc_in_t          cmd,
  output logic                      done,
  output cfc_pkg::cfc_out_t         result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cfc_pkg::CAP_W-1:0] cfg_data
);

  logic                          accept;
  logic                          ram_we, ram_re;
  logic [cfc_pkg::AW-1:0]        ram_waddr, ram_raddr;
  logic [cfc_pkg::DATA_W-1:0]    ram_rdata;
  cfc_pkg::cfc_evt_t             evt;
  cfc_pkg::cfc_resp_t            resp;
  logic [cfc_pkg::STAT_W-1:0]    enq_total, deq_total, ovf_total;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  cfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (cmd.command),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .evt       (evt),
    .resp      (resp)
  );

  cfc_ram #(
    .WIDTH (cfc_pkg::DATA_W),
    .DEPTH (cfc_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.item_data[cfc_pkg::DATA_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cfc_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .enq_total (enq_total),
    .deq_total (deq_total),
    .ovf_total (ovf_total)
  );

  assign done                  = resp.done;
  assign result.status         = resp.status;
  assign result.read_data      = resp.rd_ok ? 64'(ram_rdata) : 64'd0;
  assign result.occupancy      = cfc_pkg::OCC_W'(resp.fill);
  assign result.fill_state     = resp.fstate;
  assign result.enqueued_total = enq_total;
  assign result.dequeued_total = deq_total;
  assign result.overflow_total = ovf_total;

`ifndef SYNTHESIS
  a_done_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without a command transfer");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.fill_state == cfc_pkg::FILL_EMPTY) |-> (result.occupancy == '0))
    else $error("empty state with nonzero occupancy");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (result.read_data == 64'd0))
    else $error("refused command returned data");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(evt.enq_ok)) |-> $stable(enq_total))
    else $error("enqueue counter moved without a successful enqueue");
`endif

endmodule

// ===== sv/cfc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/cfc_stats.sv =====
// Wrapping 64-bit enqueue, dequeue and overflow counters.
module cfc_stats (
  input  logic                      clk,
  input  logic                      rst,
  input  cfc_pkg::cfc_evt_t         evt,
  output logic [cfc_pkg::STAT_W-1:0] enq_total,
  output logic [cfc_pkg::STAT_W-1:0] deq_total,
  output logic [cfc_pkg::STAT_W-1:0] ovf_total
);

  always_ff @(posedge clk) begin
    if (rst) begin
      enq_total <= '0;
      deq_total <= '0;
      ovf_total <= '0;
    end else begin
      if (evt.enq_ok) begin
        enq_total <= enq_total + cfc_pkg::STAT_W'(1);
      end
      if (evt.deq_ok) begin
        deq_total <= deq_total + cfc_pkg::STAT_W'(1);
      end
      if (evt.ovf) begin
        ovf_total <= ovf_total + cfc_pkg::STAT_W'(1);
      end
    end
  end

endmodule

// ===== sv/cfc_ctrl.sv =====
// Command decode, pointers, fill count and capacity register of the FIFO.
module cfc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  cfc_pkg::cfc_cmd_t           command,
  input  logic                        cfg_wr,
  input  logic [cfc_pkg::CAP_W-1:0]   cfg_data,
  output logic                        ram_we,
  output logic [cfc_pkg::AW-1:0]      ram_waddr,
  output logic                        ram_re,
  output logic [cfc_pkg::AW-1:0]      ram_raddr,
  output cfc_pkg::cfc_evt_t           evt,
  output cfc_pkg::cfc_resp_t          resp
);

  logic [cfc_pkg::CAP_W-1:0] capacity;
  logic [cfc_pkg::AW-1:0]    rd_ptr, rd_ptr_next;
  logic [cfc_pkg::AW-1:0]    wr_ptr, wr_ptr_next;
  logic [cfc_pkg::CNT_W-1:0] fill, fill_next;
  logic [cfc_pkg::CNT_W-1:0] cap;
  logic                      is_full, is_empty;
  logic                      status_next, rd_ok_next;
  cfc_pkg::cfc_fill_t        fstate_next;

  logic                      done, status, rd_ok;
  cfc_pkg::cfc_fill_t        fstate;

  assign cap      = cfc_pkg::cap_eff(capacity);
  assign is_full  = (fill >= cap);
  assign is_empty = (fill == '0);

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    fill_next   = fill;
    status_next = 1'b0;
    rd_ok_next  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    evt         = '0;
    if (accept) begin
      unique case (command)
        cfc_pkg::CMD_ENQ: begin
          if (is_full) begin
            status_next = 1'b1;
            evt.ovf     = 1'b1;
          end else begin
            ram_we      = 1'b1;
            wr_ptr_next = cfc_pkg::ptr_adv(wr_ptr, cap);
            fill_next   = fill + cfc_pkg::CNT_W'(1);
            evt.enq_ok  = 1'b1;
          end
        end
        cfc_pkg::CMD_DEQ, cfc_pkg::CMD_PEEK: begin
          if (is_empty) begin
            status_next = 1'b1;
          end else begin
            ram_re     = 1'b1;
            rd_ok_next = 1'b1;
            if (command == cfc_pkg::CMD_DEQ) begin
              rd_ptr_next = cfc_pkg::ptr_adv(rd_ptr, cap);
              fill_next   = fill - cfc_pkg::CNT_W'(1);
              evt.deq_ok  = 1'b1;
            end
          end
        end
        cfc_pkg::CMD_CLEAR: begin
          rd_ptr_next = '0;
          wr_ptr_next = '0;
          fill_next   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (fill_next == '0) begin
      fstate_next = cfc_pkg::FILL_EMPTY;
    end else if (fill_next >= cap) begin
      fstate_next = cfc_pkg::FILL_FULL;
    end else begin
      fstate_next = cfc_pkg::FILL_PARTIAL;
    end
  end

  assign ram_waddr = wr_ptr;
  assign ram_raddr = rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cfc_pkg::CAP_W'(16);
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      fill     <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        capacity <= cfg_data;
      end
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      fill   <= fill_next;
      done   <= accept;
    end
  end

  // Result payload: hold what the accepted command left
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      rd_ok  <= rd_ok_next;
      fstate <= fstate_next;
    end
  end

  assign resp.done   = done;
  assign resp.status = status;
  assign resp.rd_ok  = rd_ok;
  assign resp.fill   = fill;
  assign resp.fstate = fstate;

endmodule

// ===== tb/sv/fifo_stats_checker.sv =====
// Checker for the circular FIFO: predicts each response and compares it with the block.
module fifo_stats_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  cfc_pkg::cfc_in_t          cmd,
  input  logic                      done,
  input  cfc_pkg::cfc_out_t         result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [cfc_pkg::CAP_W-1:0] cfg_data,
  output int                        mismatch_count,
  output int                        outstanding
);

  logic [cfc_pkg::DATA_W-1:0] words [cfc_pkg::DEPTH];
  logic [cfc_pkg::AW-1:0]     head;
  logic [cfc_pkg::AW-1:0]     tail;
  logic [cfc_pkg::OCC_W-1:0]  held;
  logic [cfc_pkg::STAT_W-1:0] n_enq;
  logic [cfc_pkg::STAT_W-1:0] n_deq;
  logic [cfc_pkg::STAT_W-1:0] n_ovf;
  logic [cfc_pkg::CAP_W-1:0]  capacity;
  cfc_pkg::cfc_out_t          expected_responses[$];
  cfc_pkg::cfc_out_t          want;

  // Out-of-range settings: zero behaves as one, anything above DEPTH as DEPTH
  function automatic int usable_entries(logic [cfc_pkg::CAP_W-1:0] c);
    int lim;
    lim = int'(c);
    if (lim == 0) begin
      lim = 1;
    end else if (lim > cfc_pkg::DEPTH) begin
      lim = cfc_pkg::DEPTH;
    end
    return lim;
  endfunction

  function automatic logic [cfc_pkg::AW-1:0] wrap_next(logic [cfc_pkg::AW-1:0] p, int lim);
    int n;
    n = int'(p) + 1;
    return (n >= lim) ? '0 : cfc_pkg::AW'(n);
  endfunction

  function automatic cfc_pkg::cfc_out_t predict_response(cfc_pkg::cfc_in_t c);
    cfc_pkg::cfc_out_t r;
    int                lim;
    r   = '0;
    lim = usable_entries(capacity);
    case (c.command)
      cfc_pkg::CMD_ENQ: begin
        if (int'(held) >= lim) begin
          n_ovf    = n_ovf + 1'b1;
          r.status = 1'b1;
        end else begin
          words[tail] = c.item_data;
          tail        = wrap_next(tail, lim);
          held        = held + 1'b1;
          n_enq       = n_enq + 1'b1;
        end
      end
      cfc_pkg::CMD_DEQ, cfc_pkg::CMD_PEEK: begin
        if (held == '0) begin
          r.status = 1'b1;
        end else begin
          r.read_data = words[head];
          if (c.command == cfc_pkg::CMD_DEQ) begin
            head  = wrap_next(head, lim);
            held  = held - 1'b1;
            n_deq = n_deq + 1'b1;
          end
        end
      end
      default: begin
        // Clear keeps the stored words and the counters
        head = '0;
        tail = '0;
        held = '0;
      end
    endcase
    r.occupancy = held;
    if (held == '0) begin
      r.fill_state = cfc_pkg::FILL_EMPTY;
    end else if (int'(held) >= lim) begin
      r.fill_state = cfc_pkg::FILL_FULL;
    end else begin
      r.fill_state = cfc_pkg::FILL_PARTIAL;
    end
    r.enqueued_total = n_enq;
    r.dequeued_total = n_deq;
    r.overflow_total = n_ovf;
    return r;
  endfunction

  task automatic check_field(string field, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head     = '0;
      tail     = '0;
      held     = '0;
      n_enq    = '0;
      n_deq    = '0;
      n_ovf    = '0;
      capacity = cfc_pkg::CAP_W'(16);
      expected_responses.delete();
    end else begin
      if (done) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: response with none expected, expected none, actual %h",
                   $time, result);
          mismatch_count++;
        end else begin
          want = expected_responses.pop_front();
          check_field("status", want.status, result.status);
          check_field("read_data", want.read_data, result.read_data);
          check_field("occupancy", want.occupancy, result.occupancy);
          check_field("fill_state", want.fill_state, result.fill_state);
          check_field("enqueued_total", want.enqueued_total, result.enqueued_total);
          check_field("dequeued_total", want.dequeued_total, result.dequeued_total);
          check_field("overflow_total", want.overflow_total, result.overflow_total);
        end
      end
      // A command in the same transfer cycle still sees the old capacity
      if (start && !busy) begin
        expected_responses.push_back(predict_response(cmd));
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
      end
    end
    outstanding = expected_responses.size();
  end

endmodule

// ===== tb/sv/tb_circular_fifo_with_stats.sv =====
// Testbench top for the circular FIFO with statistics: stimulus, configuration and verdict.
module tb_circular_fifo_with_stats;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  cfc_pkg::cfc_in_t          cmd;
  logic                      done;
  cfc_pkg::cfc_out_t         result;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [cfc_pkg::CAP_W-1:0] cfg_data;
  int                        mismatch_count;
  int                        outstanding;
  int                        send_idle;

  circular_fifo_with_stats uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fifo_stats_checker fifo_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .done           (done),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = '1;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic issue(cfc_pkg::cfc_cmd_t op, logic [63:0] word);
    while ($urandom_range(99) < send_idle) begin
      start = 1'b0;
      @(negedge clk);
    end
    start          = 1'b1;
    cmd.command    = op;
    cmd.item_data  = word;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold off commands until every response is back
  task automatic settle();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [cfc_pkg::CAP_W-1:0] value);
    settle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Alternate fill-leaning and drain-leaning stretches so occupancy sweeps its range
  task automatic run_random(int count);
    int                r;
    bit                filling;
    cfc_pkg::cfc_cmd_t op;
    filling = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        filling = ~filling;
      end
      r = $urandom_range(99);
      if (r < 3) begin
        op = cfc_pkg::CMD_CLEAR;
      end else if (r < 15) begin
        op = cfc_pkg::CMD_PEEK;
      end else if (r < (filling ? 70 : 45)) begin
        op = cfc_pkg::CMD_ENQ;
      end else begin
        op = cfc_pkg::CMD_DEQ;
      end
      issue(op, random_word());
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    send_idle = 34;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty reads, then fill every entry so no later read hits an unwritten word
    issue(cfc_pkg::CMD_PEEK, '1);
    issue(cfc_pkg::CMD_DEQ, '1);
    issue(cfc_pkg::CMD_ENQ, 64'h0);
    issue(cfc_pkg::CMD_ENQ, '1);
    issue(cfc_pkg::CMD_ENQ, 64'h5555_5555_5555_5555);
    issue(cfc_pkg::CMD_ENQ, 64'hAAAA_AAAA_AAAA_AAAA);
    for (int i = 0; i < 12; i++) begin
      issue(cfc_pkg::CMD_ENQ, random_word());
    end
    issue(cfc_pkg::CMD_ENQ, 64'h1234_5678_9ABC_DEF0);
    issue(cfc_pkg::CMD_PEEK, '0);
    issue(cfc_pkg::CMD_DEQ, '0);
    issue(cfc_pkg::CMD_CLEAR, '1);
    issue(cfc_pkg::CMD_DEQ, '0);
    issue(cfc_pkg::CMD_ENQ, '1);
    issue(cfc_pkg::CMD_PEEK, '0);
    issue(cfc_pkg::CMD_DEQ, '0);

    write_capacity(cfc_pkg::CAP_W'(0));
    run_random(80);
    write_capacity(cfc_pkg::CAP_W'(31));
    run_random(80);

    send_idle = 51;
    write_capacity(cfc_pkg::CAP_W'(1));
    run_random(80);
    write_capacity(cfc_pkg::CAP_W'($urandom_range(2, 15)));
    run_random(80);

    send_idle = 0;
    write_capacity(cfc_pkg::CAP_W'(17));
    run_random(75);
    write_capacity(cfc_pkg::CAP_W'(16));
    run_random(78);

    settle();
    repeat (3) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
